[sv/opt_pkg.sv]
`default_nettype none

package opt_pkg;

	localparam int BUCKETS = 256;
	localparam int WAYS    = 4;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [2:0] {
		CMD_PARTIAL   = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_UPDATE    = 3'd2,
		CMD_DELETE    = 3'd3,
		CMD_UNDEFINED = 3'd4,
		CMD_UNKNOWN   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_CMD     = 3'd1,
		ST_INS_MISSING = 3'd2,
		ST_CONFLICT    = 3'd3,
		ST_BAD_FIELDS  = 3'd4,
		ST_NOT_FOUND   = 3'd5,
		ST_FULL        = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_LOOKUP
	} fsm_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [63:0] price;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

`default_nettype wire

[sv/opt_req_if.sv]
`default_nettype none

interface opt_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  cmd;
	logic        [63:0] order_id;
	logic signed [63:0] price_in;
	logic               price_present;
	logic signed [63:0] size_in;
	logic               size_present;

	modport source (
		output valid, cmd, order_id, price_in, price_present, size_in, size_present,
		input  ready
	);
	modport sink (
		input  valid, cmd, order_id, price_in, price_present, size_in, size_present,
		output ready
	);
endinterface

`default_nettype wire

[sv/opt_rsp_if.sv]
`default_nettype none

interface opt_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] price_out;
	logic               price_valid;
	logic signed [63:0] size_out;
	logic        [2:0]  status;

	modport source (
		output valid, price_out, price_valid, size_out, status,
		input  ready
	);
	modport sink (
		input  valid, price_out, price_valid, size_out, status,
		output ready
	);
endinterface

`default_nettype wire

[sv/opt_ram.sv]
`default_nettype none

module opt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/order_price_table.sv]
// Channel | Dir | Payload                                              | Handshake
// req     | in  | cmd, order_id, price_in/present, size_in/present     | valid/ready
// rsp     | out | price_out, price_valid, size_out, status             | valid/ready
//
// Each item is accepted in idle, where the bucket row is read from the table
// RAM; the lookup state then matches the ways and writes the row back.
// The result sits in an output register, so a stalled rsp holds only the
// lookup stage; a new item is taken once the previous one has left lookup.
// After reset a clearing pass writes all BUCKETS rows with ready low.
`default_nettype none

module order_price_table (
	input  wire logic clk,
	input  wire logic arst_n,
	opt_req_if.sink   req,
	opt_rsp_if.source rsp
);

	import opt_pkg::*;

	fsm_t state_q, state_nxt;
	logic [BKT_W-1:0] clr_q;

	// Latched command for the lookup cycle.
	logic [2:0]  cmd_q;
	logic [63:0] id_q;
	logic [63:0] price_q;
	logic        pp_q;
	logic [63:0] size_q;
	logic        sp_q;

	// Output register.
	logic        out_valid_q;
	logic [63:0] out_price_q;
	logic        out_pvalid_q;
	logic [63:0] out_size_q;
	logic [2:0]  out_status_q;

	// Table RAM port signals.
	logic             ram_we;
	logic [BKT_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic             ram_re;
	logic [ROW_W-1:0] ram_rdata;

	row_t row_rd;
	row_t row_wr;

	logic [WAYS-1:0]  hit_vec;
	logic [WAYS-1:0]  free_vec;
	logic [WAY_W-1:0] hit_idx;
	logic [WAY_W-1:0] free_idx;
	logic             any_hit;
	logic             any_free;

	logic        finish;
	logic        upd_we;
	logic        res_pvalid;
	logic [63:0] res_price;
	status_t     res_status;
	logic        size_pos;
	logic        size_zero_or_absent;

	opt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req.order_id[BKT_W-1:0]),
		.rdata (ram_rdata)
	);

	assign row_rd = row_t'(ram_rdata);

	// Accept only from idle; the read address is the bucket (low id bits).
	assign req.ready = (state_q == FSM_IDLE);
	assign ram_re    = req.valid && req.ready;

	// Lookup retires when the output register is free or drains this cycle.
	assign finish = (state_q == FSM_LOOKUP) && (!out_valid_q || rsp.ready);

	// Match the ways: lowest hit and lowest free way win.
	always_comb begin
		hit_vec  = '0;
		free_vec = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w]  = row_rd[w].valid && (row_rd[w].key == id_q);
			free_vec[w] = !row_rd[w].valid;
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_idx = WAY_W'(w);
			end
			if (free_vec[w]) begin
				free_idx = WAY_W'(w);
			end
		end
		any_hit  = |hit_vec;
		any_free = |free_vec;
	end

	assign size_pos            = sp_q && (size_q != '0) && !size_q[63];
	assign size_zero_or_absent = !sp_q || (size_q == '0);

	// Command decision and row update.
	always_comb begin
		row_wr     = row_rd;
		upd_we     = 1'b0;
		res_pvalid = 1'b0;
		res_price  = '0;
		res_status = ST_OK;
		case (cmd_q) inside
			CMD_PARTIAL, CMD_INSERT: begin
				if (!(pp_q && sp_q)) begin
					res_status = ST_INS_MISSING;
				end else if (any_hit) begin
					if (row_rd[hit_idx].price == price_q) begin
						res_pvalid = 1'b1;
						res_price  = price_q;
					end else begin
						res_status = ST_CONFLICT;
					end
				end else if (any_free) begin
					row_wr[free_idx].valid = 1'b1;
					row_wr[free_idx].key   = id_q;
					row_wr[free_idx].price = price_q;
					upd_we     = 1'b1;
					res_pvalid = 1'b1;
					res_price  = price_q;
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_UPDATE: begin
				if (pp_q || !size_pos) begin
					res_status = ST_BAD_FIELDS;
				end else if (any_hit) begin
					res_pvalid = 1'b1;
					res_price  = row_rd[hit_idx].price;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			CMD_DELETE: begin
				if (pp_q || !size_zero_or_absent) begin
					res_status = ST_BAD_FIELDS;
				end else if (any_hit) begin
					row_wr[hit_idx].valid = 1'b0;
					upd_we     = 1'b1;
					res_pvalid = 1'b1;
					res_price  = row_rd[hit_idx].price;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			default: begin
				res_status = ST_BAD_CMD;
			end
		endcase
	end

	// Write port: clearing sweep after reset, otherwise the row write-back.
	always_comb begin
		if (state_q == FSM_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = finish && upd_we;
			ram_waddr = id_q[BKT_W-1:0];
			ram_wdata = ROW_W'(row_wr);
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (clr_q == BKT_W'(BUCKETS - 1)) begin
					state_nxt = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (ram_re) begin
					state_nxt = FSM_LOOKUP;
				end
			end
			FSM_LOOKUP: begin
				if (finish) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: begin
				state_nxt = FSM_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Hold the command fields for the lookup cycle.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			cmd_q   <= req.cmd;
			id_q    <= req.order_id;
			price_q <= req.price_in;
			pp_q    <= req.price_present;
			size_q  <= req.size_in;
			sp_q    <= req.size_present;
		end
	end

	// Output register: load on finish, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_price_q  <= res_price;
			out_pvalid_q <= res_pvalid;
			out_size_q   <= sp_q ? size_q : '0;
			out_status_q <= res_status;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.price_out   = out_price_q;
	assign rsp.price_valid = out_pvalid_q;
	assign rsp.size_out    = out_size_q;
	assign rsp.status      = out_status_q;

endmodule

`default_nettype wire

[sv/opt_checker.sv]
`default_nettype none

module opt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] rsp_price_out,
	input wire logic        rsp_price_valid,
	input wire logic [2:0]  rsp_status
);

	import opt_pkg::*;

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Track items taken but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_price_out)
			&& $stable(rsp_status))
		else $error("rsp item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("rsp item without an accepted req item");

	a_price_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_price_valid |-> rsp_price_out == 64'd0)
		else $error("price_out nonzero without price_valid");

	a_status_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK) == rsp_price_valid)
		else $error("price_valid disagrees with status");

endmodule

bind order_price_table opt_checker u_opt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_price_out   (rsp.price_out),
	.rsp_price_valid (rsp.price_valid),
	.rsp_status      (rsp.status)
);

`default_nettype wire

[tb/sv/order_price_table_chk.sv]
`timescale 1ns / 100ps

module order_price_table_chk (
	input  wire logic clk,
	input  wire logic arst_n,
	opt_req_if        req,
	opt_rsp_if        rsp,
	output int        errors,
	output int        pending,
	output int        compared,
	output int        priced,
	output int        refused
);

	import opt_pkg::*;

	localparam int SLOTS      = BUCKETS * WAYS;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic signed [63:0] price;
		logic               price_valid;
		logic signed [63:0] size;
		status_t            status;
	} quote_t;

	// shadow of the id table; valid bits start clear like the block's
	logic [63:0] key_mem   [SLOTS];
	logic [63:0] price_mem [SLOTS];
	bit          live      [SLOTS];

	quote_t quotes_due[$];
	int     fail_cnt;
	int     compare_cnt;
	int     priced_cnt;
	int     refused_cnt;

	function automatic int find_way(int base, logic [63:0] id);
		for (int w = 0; w < WAYS; w++)
			if (live[base + w] && key_mem[base + w] == id)
				return base + w;
		return -1;
	endfunction

	function automatic int free_way(int base);
		for (int w = 0; w < WAYS; w++)
			if (!live[base + w])
				return base + w;
		return -1;
	endfunction

	// apply one command to the shadow table and return the quote it yields
	function automatic quote_t book_command(logic [2:0] op, logic [63:0] id,
			logic signed [63:0] price, logic has_price,
			logic signed [63:0] size, logic has_size);
		quote_t q;
		int     base;
		int     slot;
		logic   size_pos;
		logic   size_nil;
		base          = int'(id % 64'(BUCKETS)) * WAYS;
		size_pos      = has_size && size != 0 && !size[63];
		size_nil      = !has_size || size == 0;
		q.price       = '0;
		q.price_valid = 1'b0;
		q.size        = has_size ? size : '0;
		q.status      = ST_OK;
		case (op)
			CMD_PARTIAL, CMD_INSERT: begin
				if (!(has_price && has_size)) begin
					q.status = ST_INS_MISSING;
				end else begin
					slot = find_way(base, id);
					if (slot >= 0) begin
						if (price_mem[slot] == price) begin
							q.price       = price;
							q.price_valid = 1'b1;
						end else begin
							q.status = ST_CONFLICT;
						end
					end else begin
						slot = free_way(base);
						if (slot < 0) begin
							q.status = ST_FULL;
						end else begin
							key_mem[slot]   = id;
							price_mem[slot] = price;
							live[slot]      = 1'b1;
							q.price         = price;
							q.price_valid   = 1'b1;
						end
					end
				end
			end
			CMD_UPDATE: begin
				if (has_price || !size_pos) begin
					q.status = ST_BAD_FIELDS;
				end else begin
					slot = find_way(base, id);
					if (slot >= 0) begin
						q.price       = price_mem[slot];
						q.price_valid = 1'b1;
					end else begin
						q.status = ST_NOT_FOUND;
					end
				end
			end
			CMD_DELETE: begin
				if (has_price || !size_nil) begin
					q.status = ST_BAD_FIELDS;
				end else begin
					slot = find_way(base, id);
					if (slot >= 0) begin
						q.price       = price_mem[slot];
						q.price_valid = 1'b1;
						live[slot]    = 1'b0;
					end else begin
						q.status = ST_NOT_FOUND;
					end
				end
			end
			default: begin
				q.status = ST_BAD_CMD;
			end
		endcase
		return q;
	endfunction

	always @(posedge clk) begin : watch
		quote_t want;
		if (arst_n) begin
			// compare first, so a result that shows up with nothing outstanding is caught
			if (rsp.valid && rsp.ready) begin
				compare_cnt++;
				if (quotes_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("%0t: unexpected result price %0d valid %0b size %0d status %0d",
							$time, rsp.price_out, rsp.price_valid, rsp.size_out, rsp.status);
				end else begin
					want = quotes_due.pop_front();
					if (rsp.price_out !== want.price || rsp.price_valid !== want.price_valid ||
							rsp.size_out !== want.size || rsp.status !== want.status) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX) begin
							$write("%0t: mismatch, expected price %0d valid %0b size %0d status %0d,",
								$time, want.price, want.price_valid, want.size, want.status);
							$display(" got price %0d valid %0b size %0d status %0d",
								rsp.price_out, rsp.price_valid, rsp.size_out, rsp.status);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				want = book_command(req.cmd, req.order_id, req.price_in, req.price_present,
					req.size_in, req.size_present);
				if (want.price_valid)
					priced_cnt++;
				if (want.status == ST_FULL)
					refused_cnt++;
				quotes_due.push_back(want);
			end
		end
		errors   <= fail_cnt;
		pending  <= quotes_due.size();
		compared <= compare_cnt;
		priced   <= priced_cnt;
		refused  <= refused_cnt;
	end

endmodule

[tb/sv/order_price_table_tb.sv]
`timescale 1ns / 100ps

module order_price_table_tb;
	import opt_pkg::*;

	// random part length, the calm tail with no idling, and the pressure points
	localparam int          RANDOM_ITEMS = 1250;
	localparam int          CALM_ITEMS   = 150;
	localparam int          HOLD_AT      = 400;
	localparam int          SETTLE_AT    = 800;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          POOL         = 48;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// command codes beyond the named ones; the block must refuse them too
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam logic signed [63:0] PRICE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] PRICE_MIN = 64'sh8000_0000_0000_0000;
	localparam logic        [63:0] ID_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	opt_req_if req ();
	opt_rsp_if rsp ();

	order_price_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	int fail_count;
	int due_count;
	int compared;
	int priced;
	int refused;

	order_price_table_chk chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.errors   (fail_count),
		.pending  (due_count),
		.compared (compared),
		.priced   (priced),
		.refused  (refused)
	);

	// shared between the item sender and the result receiver
	bit          steady;     // set for the tail of the run: no idling on either side
	bit          long_hold;  // ask the receiver for one long stall
	int          sent;
	int          settles;

	// ids spread over a few buckets so that buckets fill up, hit and conflict
	logic [63:0]        id_pool [POOL];
	logic signed [63:0] quoted  [logic [63:0]];

	function automatic logic [63:0] id_in_bucket(int unsigned bkt, logic [63:0] salt);
		return salt * BUCKETS + bkt;
	endfunction

	// Offer one item and hold it until the block takes it. Before it, idle the
	// sender for a random burst now and then, so gaps land on every phase.
	task automatic offer(input logic [2:0] op, input logic [63:0] id,
			input logic signed [63:0] price, input logic has_price,
			input logic signed [63:0] size, input logic has_size);
		if (!steady && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req.cmd           <= op;
		req.order_id      <= id;
		req.price_in      <= price;
		req.price_present <= has_price;
		req.size_in       <= size;
		req.size_present  <= has_size;
		req.valid         <= 1'b1;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// Drop valid and wait until every outstanding result has come back. The
	// pending count is registered, so let the last accepted item register first.
	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		settles++;
	endtask

	// One random command: mostly well-formed traffic on pooled ids, with
	// some malformed items and pure noise mixed in.
	task automatic random_command();
		int unsigned        pick;
		logic [2:0]         op;
		logic [63:0]        id;
		logic signed [63:0] price;
		logic signed [63:0] size;
		logic               has_size;
		pick     = $urandom_range(0, 99);
		id       = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
			: id_pool[$urandom_range(0, POOL - 1)];
		price    = {$urandom, $urandom};
		size     = {$urandom, $urandom};
		has_size = 1'($urandom);
		if (pick < 10) begin
			// noise: any code, any presence flags
			offer(3'($urandom_range(0, 7)), id, price, 1'($urandom), size, has_size);
		end else if (pick < 45) begin
			// insert or partial; often repeat the last price so the entry is accepted
			op = $urandom_range(0, 1) ? CMD_INSERT : CMD_PARTIAL;
			if (quoted.exists(id) && $urandom_range(0, 1) == 1)
				price = quoted[id];
			quoted[id] = price;
			offer(op, id, price, 1'b1, size, 1'b1);
		end else if (pick < 70) begin
			// update needs no price and a positive size
			size[63] = 1'b0;
			if (size == 0)
				size = 64'sd1;
			offer(CMD_UPDATE, id, price, 1'b0, size, 1'b1);
		end else if (pick < 93) begin
			// delete takes an absent or zero size
			offer(CMD_DELETE, id, price, 1'b0, has_size ? 64'sd0 : size, has_size);
		end else begin
			// broken update or delete: negative size, price maybe present
			op = $urandom_range(0, 1) ? CMD_UPDATE : CMD_DELETE;
			offer(op, id, price, 1'($urandom), size | PRICE_MIN, 1'b1);
		end
	endtask

	// Receiver: random stall bursts, one long hold-off on request, and a
	// steady ready in the tail of the run.
	initial begin : receiver
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				// hold off long enough for the block to fill and stall its input
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				rsp.ready <= 1'b1;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Bound the run; the clearing pass after reset is small against the limit.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still outstanding", cycles, due_count);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int directed;
		// hold every input at a known value from time zero
		req.valid         <= 1'b0;
		req.cmd           <= CMD_PARTIAL;
		req.order_id      <= '0;
		req.price_in      <= '0;
		req.price_present <= 1'b0;
		req.size_in       <= '0;
		req.size_present  <= 1'b0;
		for (int k = 0; k < POOL; k++)
			id_pool[k] = id_in_bucket(((k % 8) * 29) % BUCKETS, {$urandom, $urandom});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The block keeps ready low during its clearing pass,
		// so the first offer simply waits it out.
		// Store at the top id with the largest price; re-send the same price,
		// then a different one for a conflict.
		offer(CMD_INSERT, ID_MAX, PRICE_MAX, 1'b1, PRICE_MIN, 1'b1);
		offer(CMD_PARTIAL, ID_MAX, PRICE_MAX, 1'b1, 64'sd0, 1'b1);
		offer(CMD_INSERT, ID_MAX, PRICE_MIN, 1'b1, 64'sd1, 1'b1);
		// update: the good form, then each way its fields can be wrong
		offer(CMD_UPDATE, ID_MAX, '0, 1'b0, PRICE_MAX, 1'b1);
		offer(CMD_UPDATE, ID_MAX, PRICE_MAX, 1'b1, 64'sd1, 1'b1);
		offer(CMD_UPDATE, ID_MAX, '0, 1'b0, 64'sd0, 1'b1);
		offer(CMD_UPDATE, ID_MAX, '0, 1'b0, -64'sd1, 1'b1);
		offer(CMD_UPDATE, ID_MAX, '0, 1'b0, 64'sd7, 1'b0);
		// delete: wrong fields leave the entry alone, the good form frees it
		offer(CMD_DELETE, ID_MAX, '0, 1'b0, 64'sd5, 1'b1);
		offer(CMD_DELETE, ID_MAX, PRICE_MAX, 1'b1, 64'sd0, 1'b0);
		offer(CMD_DELETE, ID_MAX, '0, 1'b0, 64'sd0, 1'b0);
		offer(CMD_DELETE, ID_MAX, '0, 1'b0, 64'sd0, 1'b1);
		offer(CMD_UPDATE, '0, '0, 1'b0, 64'sd1, 1'b1);
		// insert with a field missing
		offer(CMD_INSERT, '0, PRICE_MAX, 1'b0, 64'sd3, 1'b1);
		offer(CMD_PARTIAL, '0, PRICE_MIN, 1'b1, 64'sd3, 1'b0);
		// fill one bucket, overflow it, free a middle way and refill it
		for (int s = 1; s <= WAYS; s++)
			offer(CMD_PARTIAL, id_in_bucket(7, 64'(s)), -64'sd1000 * s, 1'b1, 64'sd10, 1'b1);
		offer(CMD_INSERT, id_in_bucket(7, 64'(WAYS + 1)), 64'sd42, 1'b1, 64'sd10, 1'b1);
		offer(CMD_DELETE, id_in_bucket(7, 64'd2), '0, 1'b0, 64'sd0, 1'b1);
		offer(CMD_INSERT, id_in_bucket(7, 64'(WAYS + 1)), 64'sd42, 1'b1, 64'sd10, 1'b1);
		offer(CMD_UPDATE, id_in_bucket(7, 64'(WAYS + 1)), '0, 1'b0, 64'sd1, 1'b1);
		// codes outside the command set
		offer(CMD_UNDEFINED, '0, '0, 1'b0, 64'sd0, 1'b0);
		offer(CMD_UNKNOWN, '0, PRICE_MAX, 1'b1, PRICE_MAX, 1'b1);
		offer(CMD_SPARE6, ID_MAX, '0, 1'b0, 64'sd1, 1'b1);
		offer(CMD_SPARE7, ID_MAX, PRICE_MIN, 1'b1, PRICE_MIN, 1'b1);
		// lowest price stored at id zero
		offer(CMD_INSERT, '0, PRICE_MIN, 1'b1, PRICE_MAX, 1'b1);
		directed = sent;
		settle();

		// Random part: one long output stall with the sender still pushing,
		// one pause for a full drain, then a calm tail.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT)
				long_hold = 1'b1;
			if (i == SETTLE_AT)
				settle();
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				steady = 1'b1;
			random_command();
		end

		// wait out the results, then give a stray late result time to show
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d commands (%0d directed) with %0d results compared.",
			sent, directed, compared);
		$display("Of those %0d returned a price and %0d hit a full bucket; %0d drains taken.",
			priced, refused, settles);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
sv/opt_pkg.sv
sv/opt_req_if.sv
sv/opt_rsp_if.sv
sv/opt_ram.sv
sv/order_price_table.sv
sv/opt_checker.sv
tb/sv/order_price_table_chk.sv
tb/sv/order_price_table_tb.sv
